// File: hdl/gyro_wiggle_return_sequencer_top_defines.svh
// assertion macros for the gyro wiggle return sequencer
`ifndef GYRO_WIGGLE_RETURN_SEQUENCER_TOP_DEFINES_SVH
`define GYRO_WIGGLE_RETURN_SEQUENCER_TOP_DEFINES_SVH

// property holds on every edge outside reset
`define GWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the next cycle
`define GWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/gwr_pkg.sv
// ----------------------------------------------------------------------------
// gwr_pkg
// types and constants shared by the gyro wiggle return sequencer
// ----------------------------------------------------------------------------
package gwr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0, PH_BIAS = 4'd1, PH_LEFT1 = 4'd2, PH_PAUSE1 = 4'd3,
    PH_RIGHT1 = 4'd4, PH_PAUSE2 = 4'd5, PH_LEFT2 = 4'd6, PH_PAUSE3 = 4'd7,
    PH_RIGHT2 = 4'd8, PH_SETTLE = 4'd9, PH_PROBE = 4'd10, PH_RETDRIVE = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    FR_NONE = 3'd0, FR_NO_SENSOR = 3'd1, FR_READ_FAIL = 3'd2,
    FR_ALREADY = 3'd3, FR_CENTERED = 3'd4, FR_TIMEOUT = 3'd5
  } reason_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0, CMD_START = 2'd1, CMD_STOP = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_QDIV, ST_PHASE, ST_OUT
  } seq_t;

  localparam logic [2:0] REG_BIAS   = 3'd0;
  localparam logic [2:0] REG_PROBE  = 3'd1;
  localparam logic [2:0] REG_TOUT   = 3'd2;
  localparam logic [2:0] REG_DEAD   = 3'd3;
  localparam logic [2:0] REG_FLIP   = 3'd4;
  localparam logic [2:0] REG_DUTY1  = 3'd5;
  localparam logic [2:0] REG_DUTY2  = 3'd6;
  localparam logic [2:0] REG_RDUTY  = 3'd7;

  localparam logic [15:0] LEN_WIG1  = 16'd210;
  localparam logic [15:0] LEN_PAUSE = 16'd120;
  localparam logic [15:0] LEN_WIG2  = 16'd170;
  localparam logic [15:0] LEN_P3    = 16'd100;
  localparam logic [15:0] CNT_MAX   = 16'hffff;

  // ceil(2^39 / 1000), exact floor division for magnitudes below 2^32
  localparam logic [29:0] RECIP_1000 = 30'd549755814;

endpackage

// File: hdl/gyro_wiggle_return_sequencer_top.sv
// ----------------------------------------------------------------------------
// gyro_wiggle_return_sequencer_top
// gyro-steered wiggle and return motor sequencer with bias estimation
// ----------------------------------------------------------------------------
// Each command word gives one status word. A start, stop, unused or
// non-integrating tick passes through accept, update and output; an
// integrating tick adds a multiply state and a state that scales the
// rate-time product by 1/1000 with a reciprocal multiply; the tick that
// closes the bias phase runs a restoring divider, one quotient bit per
// cycle over 40 bits, which is the longest case. A status word that is
// not taken holds the block in output. The block takes no new word while
// one is being worked on.
module gyro_wiggle_return_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic        sensor_ready,
  input  logic signed [21:0] yaw_rate_mdps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        motor_on,
  output logic        left_reverse,
  output logic        right_reverse,
  output logic [7:0]  duty,
  output logic [3:0]  phase_code,
  output logic        busy_res,
  output logic [2:0]  finish_reason,
  output logic signed [31:0] yaw_angle_mdeg,
  output logic signed [21:0] bias_mdps,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gwr_pkg::*;
`include "gyro_wiggle_return_sequencer_top_defines.svh"

  // configuration
  logic [15:0] bias_window, probe_time, ret_timeout;
  logic [19:0] deadband, flip_margin;
  logic [7:0]  duty1, duty2, rduty;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_window <= 16'd240; probe_time <= 16'd90; ret_timeout <= 16'd700;
      deadband <= 20'd1800; flip_margin <= 20'd300;
      duty1 <= 8'd200; duty2 <= 8'd195; rduty <= 8'd180;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIAS:  bias_window <= cfg_data[15:0];
        REG_PROBE: probe_time  <= cfg_data[15:0];
        REG_TOUT:  ret_timeout <= cfg_data[15:0];
        REG_DEAD:  deadband    <= cfg_data[19:0];
        REG_FLIP:  flip_margin <= cfg_data[19:0];
        REG_DUTY1: duty1       <= cfg_data[7:0];
        REG_DUTY2: duty2       <= cfg_data[7:0];
        REG_RDUTY: rduty       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // run state
  phase_t       phase;
  logic [31:0]  phase_start, last_time, heading, probe_abs, ret_start;
  logic [15:0]  phase_len, off_count;
  logic signed [39:0] off_sum;
  logic signed [21:0] off_value;
  logic         turn_neg;
  logic [10:0]  drive;
  reason_t      reason;

  // captured word
  cmd_t         c_cmd;
  logic [31:0]  c_now;
  logic         c_ready;

  // shared subtract-shift unit
  logic [39:0]  dvd;      // dividend, shifts out to the left
  logic [39:0]  rem;      // partial remainder
  logic [39:0]  dsr;      // divisor
  logic [5:0]   cnt;
  logic         neg;
  logic signed [29:0] prod;
  logic signed [22:0] diff;

  seq_t st, st_next;

  logic [39:0] rem_sh;
  logic [40:0] rem_sub;
  assign rem_sh  = {rem[38:0], dvd[39]};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, dsr};

  // scaled step magnitude, rate-time product over 1000
  logic [59:0] q_prod;
  logic [31:0] q_step;
  assign q_prod = dvd[29:0] * RECIP_1000;
  assign q_step = {11'd0, q_prod[59:39]};

  logic [31:0] abs_h, since_ret, since_phase;
  assign abs_h = heading[31] ? (32'd0 - heading) : heading;
  assign since_ret = c_now - ret_start;
  assign since_phase = c_now - phase_start;

  // which work a newly accepted word needs
  logic tick_go, bias_div, int_go;
  assign tick_go  = in_valid && (cmd_t'(cmd) == CMD_TICK) && sensor_ready
                    && (phase != PH_IDLE);
  assign bias_div = tick_go && (phase == PH_BIAS)
                    && ((now_ms - phase_start) >= {16'd0, phase_len});
  assign int_go   = tick_go && (phase != PH_BIAS) && (last_time != 32'd0);

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (bias_div) st_next = ST_DIV;
        else if (int_go) st_next = ST_MUL;
        else if (in_valid) st_next = ST_PHASE;
      end
      ST_DIV:  if (cnt == 6'd0) st_next = ST_PHASE;
      ST_MUL:  st_next = ST_QDIV;
      ST_QDIV: st_next = ST_PHASE;
      ST_PHASE: st_next = ST_OUT;
      ST_OUT:  if (out_ready) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (st == ST_IDLE);
    out_valid = (st == ST_OUT);
    motor_on = drive[0];
    left_reverse = drive[1];
    right_reverse = drive[2];
    duty = drive[10:3];
    phase_code = phase;
    busy_res = (phase != PH_IDLE);
    finish_reason = reason;
    yaw_angle_mdeg = heading;
    bias_mdps = off_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      phase <= PH_IDLE; phase_start <= '0; phase_len <= '0;
      off_sum <= '0; off_count <= '0; off_value <= '0; heading <= '0;
      last_time <= '0; turn_neg <= 1'b0; probe_abs <= '0; ret_start <= '0;
      drive <= '0; reason <= FR_NONE;
    end else begin
      st <= st_next;
      case (st)
        ST_IDLE: if (in_valid) begin
          c_cmd <= cmd_t'(cmd); c_now <= now_ms; c_ready <= sensor_ready;
        end
        ST_DIV: if (cnt != 6'd0) begin
          dvd <= {dvd[38:0], ~rem_sub[40]};
          rem <= rem_sub[40] ? rem_sh : rem_sub[39:0];
          cnt <= cnt - 6'd1;
        end
        ST_MUL: begin
          neg <= prod[29];
          dvd <= {10'd0, (prod[29] ? 30'(-prod) : 30'(prod))};
        end
        default: ;
      endcase

      if (st == ST_PHASE) begin : phase_step
        reason_t r;
        r = FR_NONE;
        case (c_cmd)
          CMD_START: begin
            drive <= '0;
            if (!c_ready) begin
              phase <= PH_IDLE; r = FR_NO_SENSOR;
            end else begin
              off_sum <= '0; off_count <= '0; off_value <= '0; heading <= '0;
              turn_neg <= 1'b0; probe_abs <= '0; last_time <= '0;
              phase <= PH_BIAS; phase_start <= c_now; phase_len <= bias_window;
            end
          end
          CMD_STOP: begin phase <= PH_IDLE; drive <= '0; end
          CMD_TICK: if (phase != PH_IDLE) begin
            if (!c_ready) begin
              phase <= PH_IDLE; drive <= '0; r = FR_READ_FAIL;
            end else if (phase == PH_PROBE || phase == PH_RETDRIVE) begin
              if (abs_h <= {12'd0, deadband}) begin
                phase <= PH_IDLE; drive <= '0; r = FR_CENTERED;
              end else if (since_ret >= {16'd0, ret_timeout}) begin
                phase <= PH_IDLE; drive <= '0; r = FR_TIMEOUT;
              end else if (phase == PH_PROBE && since_ret >= {16'd0, probe_time}) begin
                logic tn;
                tn = turn_neg;
                if ({1'b0, abs_h} > ({1'b0, probe_abs} + 33'(flip_margin))) tn = ~turn_neg;
                turn_neg <= tn;
                phase <= PH_RETDRIVE;
                drive <= {rduty, ~tn, tn, 1'b1};
              end
            end else if (since_phase >= {16'd0, phase_len}) begin
              case (phase)
                PH_BIAS: begin
                  if (off_count != 16'd0)
                    off_value <= 22'(neg ? (40'd0 - dvd) : dvd);
                  last_time <= c_now;
                  phase <= PH_LEFT1; phase_len <= LEN_WIG1;
                  drive <= {duty1, 1'b1, 1'b0, 1'b1};
                end
                PH_LEFT1: begin phase <= PH_PAUSE1; phase_len <= LEN_PAUSE; drive <= '0; end
                PH_PAUSE1: begin
                  phase <= PH_RIGHT1; phase_len <= LEN_WIG1;
                  drive <= {duty1, 1'b0, 1'b1, 1'b1};
                end
                PH_RIGHT1: begin phase <= PH_PAUSE2; phase_len <= LEN_PAUSE; drive <= '0; end
                PH_PAUSE2: begin
                  phase <= PH_LEFT2; phase_len <= LEN_WIG2;
                  drive <= {duty2, 1'b1, 1'b0, 1'b1};
                end
                PH_LEFT2: begin phase <= PH_PAUSE3; phase_len <= LEN_P3; drive <= '0; end
                PH_PAUSE3: begin
                  phase <= PH_RIGHT2; phase_len <= LEN_WIG2;
                  drive <= {duty2, 1'b0, 1'b1, 1'b1};
                end
                PH_RIGHT2: begin phase <= PH_SETTLE; phase_len <= LEN_PAUSE; drive <= '0; end
                PH_SETTLE: begin
                  logic tn2;
                  tn2 = (heading != 32'd0) && !heading[31];
                  ret_start <= c_now; turn_neg <= tn2; probe_abs <= abs_h;
                  if (abs_h <= {12'd0, deadband}) begin
                    phase <= PH_IDLE; drive <= '0; r = FR_ALREADY;
                  end else begin
                    phase <= PH_PROBE;
                    drive <= {rduty, ~tn2, tn2, 1'b1};
                  end
                end
                default: ;
              endcase
              phase_start <= c_now;
            end
          end
          default: ;
        endcase
        reason <= r;
      end

      // arithmetic on entry from idle into the tick work
      if (st == ST_IDLE && tick_go) begin
        if (phase == PH_BIAS) begin
          if (off_count != CNT_MAX) begin
            off_sum <= off_sum + 40'(yaw_rate_mdps);
            off_count <= off_count + 16'd1;
          end
          if (bias_div) begin
            // divide the sum including this sample
            logic signed [39:0] s;
            logic [15:0] n;
            s = (off_count != CNT_MAX) ? off_sum + 40'(yaw_rate_mdps) : off_sum;
            n = (off_count != CNT_MAX) ? off_count + 16'd1 : off_count;
            neg <= s[39];
            dvd <= s[39] ? 40'(-s) : s;
            rem <= '0; dsr <= {24'd0, n}; cnt <= 6'd40;
          end
        end else if (last_time == 32'd0) begin
          last_time <= now_ms;
        end else begin
          diff <= 23'(yaw_rate_mdps) - 23'(off_value);
          last_time <= now_ms;
        end
      end

      // finish integration
      if (st == ST_QDIV)
        heading <= heading + (neg ? (32'd0 - q_step) : q_step);
    end
  end

  // dt must come from the time before last_time is updated
  logic [31:0] dt_hold;
  always_ff @(posedge clk) begin
    if (st == ST_IDLE) dt_hold <= ((now_ms - last_time) > 32'd80) ? 32'd80 :
                        ((now_ms - last_time) == 32'd0) ? 32'd1 : (now_ms - last_time);
  end
  assign prod = 30'(diff) * $signed({23'd0, dt_hold[6:0]});

  `GWR_ASSERT(a_busy_phase, busy_res == (phase_code != PH_IDLE), "busy mismatch")
  `GWR_ASSERT(a_no_both, !(in_ready && out_valid), "ready while result pending")
  `GWR_ASSERT(a_motor_off, motor_on || (duty == 8'd0 && !left_reverse), "stopped not clear")
  `GWR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule
